>>> hw/rtl/fmvu_pkg.sv
// Shared types, constants and decode helpers for the packed FM voice unpacker.
`default_nettype none
package fmvu_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned MAX_RESULTS     = 3;

  // Byte layout of one packed voice record
  localparam logic [6:0] OP_AREA_BYTES = 7'd102;
  localparam logic [6:0] LAST_BYTE     = 7'd127;
  localparam logic [4:0] OP_LAST_SUB   = 5'd16;

  // One decoded input byte: up to three index/value results
  typedef struct packed {
    logic [4:0]                   slot;
    logic                         done;
    logic [1:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  idx;
    logic [MAX_RESULTS-1:0][7:0]  val;
  } fmvu_run_t;

  // First parameter index of an operator block (21 parameters each)
  function automatic logic [7:0] op_base(input logic [2:0] op);
    op_base = {1'b0, op, 4'b0000} + {3'b000, op, 2'b00} + {5'b00000, op};
  endfunction

  // floor(v*99/255) for v above 99, v itself otherwise
  function automatic logic [7:0] scale99(input logic [6:0] v);
    logic [7:0] r;
    case (v)
      7'd100:  r = 8'd38;
      7'd101:  r = 8'd39;
      7'd102:  r = 8'd39;
      7'd103:  r = 8'd39;
      7'd104:  r = 8'd40;
      7'd105:  r = 8'd40;
      7'd106:  r = 8'd41;
      7'd107:  r = 8'd41;
      7'd108:  r = 8'd41;
      7'd109:  r = 8'd42;
      7'd110:  r = 8'd42;
      7'd111:  r = 8'd43;
      7'd112:  r = 8'd43;
      7'd113:  r = 8'd43;
      7'd114:  r = 8'd44;
      7'd115:  r = 8'd44;
      7'd116:  r = 8'd45;
      7'd117:  r = 8'd45;
      7'd118:  r = 8'd45;
      7'd119:  r = 8'd46;
      7'd120:  r = 8'd46;
      7'd121:  r = 8'd46;
      7'd122:  r = 8'd47;
      7'd123:  r = 8'd47;
      7'd124:  r = 8'd48;
      7'd125:  r = 8'd48;
      7'd126:  r = 8'd48;
      7'd127:  r = 8'd49;
      default: r = {1'b0, v};
    endcase
    scale99 = r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fmvu_front.sv
// Front end: tracks byte position and decodes each byte into a run of results.
`default_nettype none
module fmvu_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_packed_byte,
  input  wire logic [4:0]      in_voice_slot,
  input  wire logic            in_start_voice,
  input  wire logic            q_full,
  output logic                 q_push,
  output fmvu_pkg::fmvu_run_t  q_wdata
);

  logic [6:0] pos_r, pos_nxt;
  logic [2:0] op_r,  op_nxt;
  logic [4:0] sub_r, sub_nxt;
  logic [6:0] pos;
  logic [2:0] op;
  logic [4:0] sub;
  logic [7:0] base;
  logic [6:0] b7;
  fmvu_pkg::fmvu_run_t run;

  assign q_push = in_valid && !q_full;

  // Restart drops the current position
  assign pos  = in_start_voice ? 7'd0 : pos_r;
  assign op   = in_start_voice ? 3'd0 : op_r;
  assign sub  = in_start_voice ? 5'd0 : sub_r;
  assign base = fmvu_pkg::op_base(op);
  assign b7   = in_packed_byte[6:0];

  always_comb begin
    pos_nxt = pos + 7'd1;
    op_nxt  = op;
    sub_nxt = sub + 5'd1;
    if (pos == fmvu_pkg::LAST_BYTE) begin
      op_nxt  = 3'd0;
      sub_nxt = 5'd0;
    end else if (pos >= fmvu_pkg::OP_AREA_BYTES) begin
      // hold operator and sub-byte counters through the global area
      sub_nxt = sub;
    end else if (sub == fmvu_pkg::OP_LAST_SUB) begin
      op_nxt  = op + 3'd1;
      sub_nxt = 5'd0;
    end
  end

  always_comb begin
    run      = '0;
    run.slot = in_voice_slot;
    run.done = (pos == fmvu_pkg::LAST_BYTE);
    if (pos < fmvu_pkg::OP_AREA_BYTES) begin
      unique case (sub) inside
        [5'd0:5'd10]: begin
          run.cnt    = 2'd1;
          run.idx[0] = base + {3'd0, sub};
          run.val[0] = in_packed_byte;
        end
        5'd11: begin
          run.cnt    = 2'd2;
          run.idx[0] = base + 8'd11;
          run.val[0] = {6'd0, in_packed_byte[1:0]};
          run.idx[1] = base + 8'd12;
          run.val[1] = {6'd0, in_packed_byte[3:2]};
        end
        5'd12: begin
          run.cnt    = 2'd2;
          run.idx[0] = base + 8'd13;
          run.val[0] = {5'd0, in_packed_byte[2:0]};
          run.idx[1] = base + 8'd20;
          run.val[1] = {4'd0, in_packed_byte[6:3]};
        end
        5'd13: begin
          run.cnt    = 2'd2;
          run.idx[0] = base + 8'd14;
          run.val[0] = {6'd0, in_packed_byte[1:0]};
          run.idx[1] = base + 8'd15;
          run.val[1] = {5'd0, in_packed_byte[4:2]};
        end
        5'd14: begin
          run.cnt    = 2'd1;
          run.idx[0] = base + 8'd16;
          run.val[0] = {1'b0, b7};
        end
        5'd15: begin
          run.cnt    = 2'd2;
          run.idx[0] = base + 8'd17;
          run.val[0] = {7'd0, in_packed_byte[0]};
          run.idx[1] = base + 8'd18;
          run.val[1] = {3'd0, in_packed_byte[5:1]};
        end
        default: begin
          run.cnt    = 2'd1;
          run.idx[0] = base + 8'd19;
          run.val[0] = {1'b0, b7};
        end
      endcase
    end else begin
      unique case (pos) inside
        [7'd102:7'd109]: begin
          run.cnt    = 2'd1;
          run.idx[0] = {1'b0, pos} + 8'd24;
          run.val[0] = fmvu_pkg::scale99(b7);
        end
        7'd110: begin
          run.cnt    = 2'd1;
          run.idx[0] = 8'd134;
          run.val[0] = {3'd0, in_packed_byte[4:0]};
        end
        7'd111: begin
          run.cnt    = 2'd2;
          run.idx[0] = 8'd135;
          run.val[0] = {5'd0, in_packed_byte[2:0]};
          run.idx[1] = 8'd136;
          run.val[1] = {7'd0, in_packed_byte[3]};
        end
        [7'd112:7'd115]: begin
          run.cnt    = 2'd1;
          run.idx[0] = {1'b0, pos} + 8'd25;
          run.val[0] = {1'b0, b7};
        end
        7'd116: begin
          run.cnt    = 2'd3;
          run.idx[0] = 8'd141;
          run.val[0] = {7'd0, in_packed_byte[0]};
          run.idx[1] = 8'd142;
          run.val[1] = {5'd0, in_packed_byte[3:1]};
          run.idx[2] = 8'd143;
          run.val[2] = {5'd0, in_packed_byte[6:4]};
        end
        7'd117: begin
          run.cnt    = 2'd1;
          run.idx[0] = 8'd144;
          run.val[0] = {1'b0, b7};
        end
        default: begin
          run.cnt    = 2'd1;
          run.idx[0] = {1'b0, pos} + 8'd27;
          run.val[0] = {1'b0, b7};
        end
      endcase
    end
  end

  assign q_wdata = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 7'd0;
      op_r  <= 3'd0;
      sub_r <= 5'd0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
      op_r  <= op_nxt;
      sub_r <= sub_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/fmvu_queue.sv
// Small queue of decoded runs between the front and back ends.
`default_nettype none
module fmvu_queue #(
  parameter int unsigned DEPTH = fmvu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire fmvu_pkg::fmvu_run_t wdata,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output fmvu_pkg::fmvu_run_t  rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  fmvu_pkg::fmvu_run_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/fmvu_back.sv
// Back end: walks each queued run and presents one result per transaction.
`default_nettype none
module fmvu_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire fmvu_pkg::fmvu_run_t q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [4:0]           out_slot_echo,
  output logic [7:0]           out_param_index,
  output logic [7:0]           out_param_value,
  output logic                 out_last_of_run,
  output logic                 out_voice_done
);

  logic [1:0] sel_r;
  logic       valid_r;
  logic [4:0] slot_r;
  logic [7:0] idx_r, val_r;
  logic       last_r, done_r;
  logic       load, is_last;

  // Output register takes a new result when empty or being drained
  assign load    = q_not_empty && (!valid_r || !out_stall);
  assign is_last = (sel_r == (q_rdata.cnt - 2'd1));
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sel_r   <= is_last ? 2'd0 : sel_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= q_rdata.slot;
      idx_r  <= q_rdata.idx[sel_r];
      val_r  <= q_rdata.val[sel_r];
      last_r <= is_last;
      done_r <= q_rdata.done;
    end
  end

  assign out_valid       = valid_r;
  assign out_slot_echo   = slot_r;
  assign out_param_index = idx_r;
  assign out_param_value = val_r;
  assign out_last_of_run = last_r;
  assign out_voice_done  = done_r;

endmodule
`default_nettype wire

>>> hw/rtl/fm_voice_packed_unpack_unit.sv
// Top level of the packed FM voice unpacker: front decode, run queue, result serializer.
// Path: an accepted byte is written into the run queue, then its first result is loaded into the output register.
// Throughput: one result per cycle from the back end while out_stall is low; a byte
//   yields 1 to 3 results (the parameters it decodes to); the front end takes one byte
//   per cycle while the run queue has room.
// Reset (rst_n low, synchronous): byte position returns to zero, queue and output empty.
`default_nettype none
module fm_voice_packed_unpack_unit #(
  parameter int unsigned QUEUE_DEPTH = fmvu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_packed_byte,
  input  wire logic [4:0] in_voice_slot,
  input  wire logic       in_start_voice,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [4:0]      out_slot_echo,
  output logic [7:0]      out_param_index,
  output logic [7:0]      out_param_value,
  output logic            out_last_of_run,
  output logic            out_voice_done
);

  logic                q_push, q_pop, q_full, q_not_empty;
  fmvu_pkg::fmvu_run_t q_wdata, q_rdata;

  assign in_stall = q_full;

  fmvu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_packed_byte (in_packed_byte),
    .in_voice_slot  (in_voice_slot),
    .in_start_voice (in_start_voice),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  fmvu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  fmvu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot_echo   (out_slot_echo),
    .out_param_index (out_param_index),
    .out_param_value (out_param_value),
    .out_last_of_run (out_last_of_run),
    .out_voice_done  (out_voice_done)
  );

endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench for the packed FM voice unpacker: directed decode cases, full voices, noisy streams.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned OP_BYTES   = 17;
  localparam int unsigned OP_PARAMS  = 21;
  localparam int unsigned OP_BLOCKS  = 6;
  localparam int unsigned VOICE_LEN  = 128;
  localparam int unsigned SCALE_BASE = 126;
  localparam int unsigned TAIL_BASE  = 145;
  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    logic [4:0] slot;
    logic [7:0] idx;
    logic [7:0] val;
    logic       last;
    logic       done;
  } param_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_packed_byte = 8'h00;
  logic [4:0] in_voice_slot = 5'h00;
  logic       in_start_voice = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_slot_echo;
  logic [7:0] out_param_index;
  logic [7:0] out_param_value;
  logic       out_last_of_run;
  logic       out_voice_done;

  param_t      pending_params[$];
  logic [6:0]  voice_pos = 7'd0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count = 0;

  fm_voice_packed_unpack_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_packed_byte  (in_packed_byte),
    .in_voice_slot   (in_voice_slot),
    .in_start_voice  (in_start_voice),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot_echo   (out_slot_echo),
    .out_param_index (out_param_index),
    .out_param_value (out_param_value),
    .out_last_of_run (out_last_of_run),
    .out_voice_done  (out_voice_done)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] scale_level(input logic [6:0] v);
    int unsigned w;
    w = 32'(v);
    if (w <= 99) begin
      return w[7:0];
    end
    w = (w * 99) / 255;
    return w[7:0];
  endfunction

  // Decode one accepted byte and queue the parameters it yields.
  function automatic void predict_params(input logic [7:0] b, input logic [4:0] slot,
                                         input logic start);
    logic [7:0]  idx[3];
    logic [7:0]  val[3];
    int unsigned n;
    int unsigned p;
    int unsigned sub;
    int unsigned base;
    param_t      r;
    n = 0;
    if (start) begin
      voice_pos = 7'd0;
    end
    p = 32'(voice_pos);
    if (p < OP_BLOCKS * OP_BYTES) begin
      sub  = p % OP_BYTES;
      base = (p / OP_BYTES) * OP_PARAMS;
      case (sub)
        11: begin
          idx[0] = 8'(base + 11); val[0] = {6'd0, b[1:0]};
          idx[1] = 8'(base + 12); val[1] = {6'd0, b[3:2]};
          n = 2;
        end
        12: begin
          idx[0] = 8'(base + 13); val[0] = {5'd0, b[2:0]};
          idx[1] = 8'(base + 20); val[1] = {4'd0, b[6:3]};
          n = 2;
        end
        13: begin
          idx[0] = 8'(base + 14); val[0] = {6'd0, b[1:0]};
          idx[1] = 8'(base + 15); val[1] = {5'd0, b[4:2]};
          n = 2;
        end
        14: begin
          idx[0] = 8'(base + 16); val[0] = {1'b0, b[6:0]};
          n = 1;
        end
        15: begin
          idx[0] = 8'(base + 17); val[0] = {7'd0, b[0]};
          idx[1] = 8'(base + 18); val[1] = {3'd0, b[5:1]};
          n = 2;
        end
        16: begin
          idx[0] = 8'(base + 19); val[0] = {1'b0, b[6:0]};
          n = 1;
        end
        default: begin
          // Raw pass-through of the first eleven operator bytes
          idx[0] = 8'(base + sub); val[0] = b;
          n = 1;
        end
      endcase
    end else if (p < 110) begin
      idx[0] = 8'(SCALE_BASE + (p - 32'(fmvu_pkg::OP_AREA_BYTES)));
      val[0] = scale_level(b[6:0]);
      n = 1;
    end else if (p == 110) begin
      idx[0] = 8'd134; val[0] = {3'd0, b[4:0]};
      n = 1;
    end else if (p == 111) begin
      idx[0] = 8'd135; val[0] = {5'd0, b[2:0]};
      idx[1] = 8'd136; val[1] = {7'd0, b[3]};
      n = 2;
    end else if (p < 116) begin
      idx[0] = 8'(137 + (p - 112)); val[0] = {1'b0, b[6:0]};
      n = 1;
    end else if (p == 116) begin
      idx[0] = 8'd141; val[0] = {7'd0, b[0]};
      idx[1] = 8'd142; val[1] = {5'd0, b[3:1]};
      idx[2] = 8'd143; val[2] = {5'd0, b[6:4]};
      n = 3;
    end else if (p == 117) begin
      idx[0] = 8'd144; val[0] = {1'b0, b[6:0]};
      n = 1;
    end else begin
      idx[0] = 8'(TAIL_BASE + (p - 118)); val[0] = {1'b0, b[6:0]};
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      r.slot = slot;
      r.idx  = idx[k];
      r.val  = val[k];
      r.last = (k == n - 1);
      r.done = (voice_pos == fmvu_pkg::LAST_BYTE);
      pending_params.push_back(r);
    end
    voice_pos = voice_pos + 7'd1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Send one byte; returns at the edge where the transaction was accepted.
  task automatic send_byte(input logic [7:0] b, input logic [4:0] slot, input logic start);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_byte <= b;
    in_voice_slot  <= slot;
    in_start_voice <= start;
    forever begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
      if (taken) begin
        break;
      end
    end
    predict_params(b, slot, start);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_directed();
    send_byte(8'hFF, 5'd31, 1'b1);
    send_byte(8'h00, 5'd0, 1'b0);
    for (int i = 2; i < 11; i++) begin
      send_byte((i % 2) ? 8'h80 : 8'h7F, (i % 2) ? 5'h15 : 5'h0A, 1'b0);
    end
    // Split-field bytes of the first operator with every bit set
    for (int i = 11; i < OP_BYTES; i++) begin
      send_byte(8'hFF, 5'h1F, 1'b0);
    end
    send_byte(8'h00, 5'd0, 1'b0);
    // Restart in the middle of a voice
    send_byte(8'h5A, 5'h15, 1'b1);
    send_byte(8'hA5, 5'h0A, 1'b0);
  endtask

  // Full voice; with start clear it relies on the wrap after the last byte.
  task automatic test_full_voice(input logic flag_start);
    for (int i = 0; i < VOICE_LEN; i++) begin
      send_byte(pick_byte(), 5'($urandom_range(0, 31)), (i == 0) ? flag_start : 1'b0);
    end
  endtask

  task automatic test_noisy_stream(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      send_byte(pick_byte(), 5'($urandom_range(0, 31)), $urandom_range(0, 11) == 0);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(negedge clk) begin
    param_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_params.size() == 0) begin
        report_mismatch($sformatf("unexpected result idx=%0d val=%0d",
                                  out_param_index, out_param_value));
      end else begin
        want = pending_params.pop_front();
        if (out_slot_echo !== want.slot || out_param_index !== want.idx ||
            out_param_value !== want.val || out_last_of_run !== want.last ||
            out_voice_done !== want.done) begin
          report_mismatch($sformatf(
            "got slot=%0d idx=%0d val=%0d last=%b done=%b, want %0d %0d %0d %b %b",
            out_slot_echo, out_param_index, out_param_value, out_last_of_run,
            out_voice_done, want.slot, want.idx, want.val, want.last, want.done));
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[fm_voice_packed_unpack_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 8;
    recv_stall_pct = 50;
    test_directed();
    test_full_voice(1'b1);

    send_idle_pct  = 50;
    recv_stall_pct = 8;
    test_full_voice(1'b0);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_noisy_stream(100);

    in_valid <= 1'b0;
    while (pending_params.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("[fm_voice_packed_unpack_unit] OK");
    end else begin
      $display("[fm_voice_packed_unpack_unit] ERROR");
    end
    $finish;
  end

endmodule
